// ===== rtl/pdps_pkg.sv =====
// ----------------------------------------------------------------------------
// pdps_pkg
// Shared types and constants for the PD position servo with saturation.
// ----------------------------------------------------------------------------
package pdps_pkg;

  localparam int MAG_W   = 62;
  localparam int HALF_W  = 31;
  localparam int SQ_W    = 64;
  localparam int APB_AW  = 6;
  localparam int APB_DW  = 64;
  localparam int GREG_W  = 60;

  localparam logic [MAG_W-1:0] CAP = {MAG_W{1'b1}};

  localparam logic [GREG_W-1:0] PROP_RESET = 60'd450360392234188800;
  localparam logic [GREG_W-1:0] DIFF_RESET = 60'd45036039223418880;
  localparam logic [31:0]       MAXVEL_RESET = 32'd6554;
  localparam logic [31:0]       MAXACC_RESET = 32'd0;
  localparam logic [2:0]        AXSEL_RESET  = 3'd7;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_PROP   = 3'd1,
    REG_DIFF   = 3'd2,
    REG_MAXVEL = 3'd3,
    REG_MAXACC = 3'd4,
    REG_AXSEL  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic              per_axis;
    logic [GREG_W-1:0] prop_gains;
    logic [GREG_W-1:0] diff_gains;
    logic [31:0]       max_velocity;
    logic [31:0]       max_acceleration;
    logic [2:0]        axis_select;
  } cfg_t;

  typedef logic [MAG_W-1:0] mag_t;
  typedef mag_t [2:0]       mag3_t;

  typedef struct packed {
    logic  en;
    mag3_t a;
    mag_t  lim;
  } side_t;

  typedef struct packed {
    logic [SQ_W-1:0] n;
    logic [SQ_W-1:0] r;
  } rt_t;

  typedef struct packed {
    logic [MAG_W:0]   rem;
    logic [MAG_W-1:0] q;
    logic [MAG_W-1:0] lo;
  } dv_t;

  typedef struct packed {
    logic [2*HALF_W-1:0] p00;
    logic [2*HALF_W-1:0] p01;
    logic [2*HALF_W-1:0] p10;
    logic [2*HALF_W-1:0] p11;
  } pp_t;

  typedef struct packed {
    mag3_t      vm;
    logic [2:0] vneg;
    logic [2:0] dneg;
  } vtag_t;

endpackage

// ===== rtl/pdps_regs.sv =====
// ----------------------------------------------------------------------------
// pdps_regs
// APB configuration registers, 64-bit data, register i at byte address 8*i.
// ----------------------------------------------------------------------------
module pdps_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pdps_pkg::APB_AW-1:0] paddr,
  input  logic [pdps_pkg::APB_DW-1:0] pwdata,
  output logic [pdps_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output pdps_pkg::cfg_t              cfg
);
  import pdps_pkg::*;

  cfg_reg_e idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = cfg_reg_e'(paddr[APB_AW-1:3]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.per_axis         <= 1'b0;
      cfg.prop_gains       <= PROP_RESET;
      cfg.diff_gains       <= DIFF_RESET;
      cfg.max_velocity     <= MAXVEL_RESET;
      cfg.max_acceleration <= MAXACC_RESET;
      cfg.axis_select      <= AXSEL_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_MODE:   cfg.per_axis         <= pwdata[0];
        REG_PROP:   cfg.prop_gains       <= pwdata[GREG_W-1:0];
        REG_DIFF:   cfg.diff_gains       <= pwdata[GREG_W-1:0];
        REG_MAXVEL: cfg.max_velocity     <= pwdata[31:0];
        REG_MAXACC: cfg.max_acceleration <= pwdata[31:0];
        REG_AXSEL:  cfg.axis_select      <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:   prdata = APB_DW'(cfg.per_axis);
      REG_PROP:   prdata = APB_DW'(cfg.prop_gains);
      REG_DIFF:   prdata = APB_DW'(cfg.diff_gains);
      REG_MAXVEL: prdata = APB_DW'(cfg.max_velocity);
      REG_MAXACC: prdata = APB_DW'(cfg.max_acceleration);
      REG_AXSEL:  prdata = APB_DW'(cfg.axis_select);
      default:    prdata = '0;
    endcase
  end

endmodule

// ===== rtl/pdps_norm_limit.sv =====
// ----------------------------------------------------------------------------
// pdps_norm_limit
// Pipelined 3-vector norm limiter: Euclidean norm, compare against a limit,
// and, when enabled and the norm exceeds the limit, per-component floor(|c| * lim / norm) by restoring division.
// ----------------------------------------------------------------------------
module pdps_norm_limit #(
  parameter int TAG_W = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_en,
  input  pdps_pkg::mag3_t     in_mag,
  input  pdps_pkg::mag_t      in_lim,
  input  logic [TAG_W-1:0]    in_tag,
  output logic                out_valid,
  output pdps_pkg::mag3_t     out_mag,
  output logic [TAG_W-1:0]    out_tag
);
  import pdps_pkg::*;

  localparam int SQ_STEPS  = SQ_W / 2;
  localparam int DIV_STEPS = MAG_W;
  localparam int K_MX      = 0;
  localparam int K_S       = 1;
  localparam int K_T       = 2;
  localparam int K_SQ      = 3;
  localparam int K_SUM     = 4;
  localparam int K_RT0     = 5;
  localparam int K_RT_END  = K_RT0 + SQ_STEPS - 1;
  localparam int K_NRM     = K_RT_END + 1;
  localparam int K_CMP     = K_NRM + 1;
  localparam int K_PP      = K_CMP + 1;
  localparam int K_PROD    = K_PP + 1;
  localparam int K_DV0     = K_PROD + 1;
  localparam int K_DV_END  = K_DV0 + DIV_STEPS - 1;
  localparam int K_OUT     = K_DV_END + 1;
  localparam int LAT       = K_OUT + 1;

  function automatic logic [4:0] shift_of(mag_t m);
    logic [5:0] bl;
    bl = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (m[i]) bl = 6'(i + 1);
    end
    return (bl > 6'(HALF_W)) ? 5'(bl - 6'(HALF_W)) : 5'd0;
  endfunction

  function automatic rt_t rt_step(rt_t x, logic [SQ_W-1:0] b);
    logic [SQ_W-1:0] rb;
    rt_t             y;
    rb = x.r + b;
    if (x.n >= rb) begin
      y.n = x.n - rb;
      y.r = (x.r >> 1) + b;
    end else begin
      y.n = x.n;
      y.r = x.r >> 1;
    end
    return y;
  endfunction

  function automatic dv_t dv_step(dv_t x, logic [MAG_W:0] c);
    logic [MAG_W+1:0] t;
    dv_t              y;
    t    = {x.rem, x.lo[MAG_W-1]};
    y.lo = x.lo << 1;
    if (t >= {1'b0, c}) begin
      y.rem = (MAG_W+1)'(t - {1'b0, c});
      y.q   = {x.q[MAG_W-2:0], 1'b1};
    end else begin
      y.rem = t[MAG_W:0];
      y.q   = {x.q[MAG_W-2:0], 1'b0};
    end
    return y;
  endfunction

  logic                vld_q  [LAT];
  side_t               side_q [LAT];
  logic [TAG_W-1:0]    tag_q  [LAT];
  mag_t                mx_q;
  logic [4:0]          s_q    [K_S:K_RT_END];
  logic [HALF_W-1:0]   t_q    [3];
  logic [2*HALF_W-1:0] sq_q   [3];
  logic [SQ_W-1:0]     sum_q;
  rt_t                 rt_q   [SQ_STEPS];
  logic [MAG_W:0]      nrm_q;
  logic                sc_q   [K_CMP:K_DV_END];
  logic [MAG_W:0]      c_q    [K_CMP:K_DV_END-1];
  pp_t                 pp_q   [3];
  logic [2*MAG_W-1:0]  prod_q [3];
  dv_t                 dv_q   [DIV_STEPS][3];
  mag3_t               out_q;
  side_t               side_in;

  assign side_in.en  = in_en;
  assign side_in.a   = in_mag;
  assign side_in.lim = in_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LAT; k++) vld_q[k] <= 1'b0;
    end else begin
      vld_q[0] <= in_valid;
      for (int k = 1; k < LAT; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk) begin
    side_q[0] <= side_in;
    tag_q[0]  <= in_tag;
    for (int k = 1; k < LAT; k++) begin
      side_q[k] <= side_q[k-1];
      tag_q[k]  <= tag_q[k-1];
    end
  end

  // norm front end: max, shift, square, sum
  always_ff @(posedge clk) begin
    if (in_mag[0] >= in_mag[1] && in_mag[0] >= in_mag[2]) mx_q <= in_mag[0];
    else if (in_mag[1] >= in_mag[2])                      mx_q <= in_mag[1];
    else                                                  mx_q <= in_mag[2];
    s_q[K_S] <= shift_of(mx_q);
    for (int k = K_S + 1; k <= K_RT_END; k++) s_q[k] <= s_q[k-1];
    for (int i = 0; i < 3; i++) begin
      t_q[i]  <= HALF_W'(side_q[K_S].a[i] >> s_q[K_S]);
      sq_q[i] <= (2*HALF_W)'(t_q[i]) * (2*HALF_W)'(t_q[i]);
    end
    sum_q <= SQ_W'(sq_q[0]) + SQ_W'(sq_q[1]) + SQ_W'(sq_q[2]);
  end

  // integer square root, one result bit per stage
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_rt
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        rt_q[k] <= rt_step('{n: sum_q, r: '0}, SQ_W'(1) << (SQ_W - 2));
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        rt_q[k] <= rt_step(rt_q[k-1], SQ_W'(1) << (SQ_W - 2 - 2 * k));
      end
    end
  end

  // norm, compare, partial products, product
  always_ff @(posedge clk) begin
    nrm_q <= (MAG_W+1)'(rt_q[SQ_STEPS-1].r[SQ_STEPS-1:0]) << s_q[K_RT_END];
    sc_q[K_CMP] <= side_q[K_NRM].en && (nrm_q > (MAG_W+1)'(side_q[K_NRM].lim));
    c_q[K_CMP]  <= nrm_q;
    for (int k = K_CMP + 1; k <= K_DV_END; k++) sc_q[k] <= sc_q[k-1];
    for (int k = K_CMP + 1; k < K_DV_END; k++)  c_q[k]  <= c_q[k-1];
    for (int i = 0; i < 3; i++) begin
      pp_q[i].p00 <= (2*HALF_W)'(side_q[K_CMP].a[i][HALF_W-1:0]) *
                     (2*HALF_W)'(side_q[K_CMP].lim[HALF_W-1:0]);
      pp_q[i].p01 <= (2*HALF_W)'(side_q[K_CMP].a[i][HALF_W-1:0]) *
                     (2*HALF_W)'(side_q[K_CMP].lim[MAG_W-1:HALF_W]);
      pp_q[i].p10 <= (2*HALF_W)'(side_q[K_CMP].a[i][MAG_W-1:HALF_W]) *
                     (2*HALF_W)'(side_q[K_CMP].lim[HALF_W-1:0]);
      pp_q[i].p11 <= (2*HALF_W)'(side_q[K_CMP].a[i][MAG_W-1:HALF_W]) *
                     (2*HALF_W)'(side_q[K_CMP].lim[MAG_W-1:HALF_W]);
      prod_q[i] <= ((2*MAG_W)'(pp_q[i].p11) << (2*HALF_W)) +
                   (((2*MAG_W)'(pp_q[i].p01) + (2*MAG_W)'(pp_q[i].p10)) << HALF_W) +
                   (2*MAG_W)'(pp_q[i].p00);
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_dv
    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        for (int i = 0; i < 3; i++) begin
          dv_q[j][i] <= dv_step('{rem: (MAG_W+1)'(prod_q[i][2*MAG_W-1:MAG_W]),
                                  q: '0, lo: prod_q[i][MAG_W-1:0]}, c_q[K_PROD]);
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        for (int i = 0; i < 3; i++) dv_q[j][i] <= dv_step(dv_q[j-1][i], c_q[K_DV0+j-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      out_q[i] <= sc_q[K_DV_END] ? dv_q[DIV_STEPS-1][i].q : side_q[K_DV_END].a[i];
    end
  end

  assign out_valid = vld_q[K_OUT];
  assign out_mag   = out_q;
  assign out_tag   = tag_q[K_OUT];

endmodule

// ===== rtl/pd_position_servo_saturated_core.sv =====
// ----------------------------------------------------------------------------
// pd_position_servo_saturated_core
// PD position servo: 3-axis goal/pos/vel in, commanded acceleration out, with
// velocity and acceleration saturation in per-axis or scalar-gain mode.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  item in  | start, busy            | goal_x..z, pos_x..z, vel_x..z
//  item out | done (one-cycle pulse) | accel_row0..2, row_count
//  config   | APB psel/penable/...   | paddr, pwdata, prdata
//
// One item per cycle; busy stays low. Most of the pipeline lies in the two
// norm limiters (32-step square root and 62-step divider each).
// Reset clears the valid bits of every stage; config keeps its reset values.
// Results cannot be stalled: done pulses once per accepted item, in order.
// ----------------------------------------------------------------------------
module pd_position_servo_saturated_core #(
  parameter int DATA_WIDTH = 32,
  parameter int GAIN_WIDTH = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [DATA_WIDTH-1:0]  goal_x,
  input  logic signed [DATA_WIDTH-1:0]  goal_y,
  input  logic signed [DATA_WIDTH-1:0]  goal_z,
  input  logic signed [DATA_WIDTH-1:0]  pos_x,
  input  logic signed [DATA_WIDTH-1:0]  pos_y,
  input  logic signed [DATA_WIDTH-1:0]  pos_z,
  input  logic signed [DATA_WIDTH-1:0]  vel_x,
  input  logic signed [DATA_WIDTH-1:0]  vel_y,
  input  logic signed [DATA_WIDTH-1:0]  vel_z,
  output logic                          done,
  output logic signed [DATA_WIDTH-1:0]  accel_row0,
  output logic signed [DATA_WIDTH-1:0]  accel_row1,
  output logic signed [DATA_WIDTH-1:0]  accel_row2,
  output logic [1:0]                    row_count,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pdps_pkg::APB_AW-1:0]   paddr,
  input  logic [pdps_pkg::APB_DW-1:0]   pwdata,
  output logic [pdps_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import pdps_pkg::*;

  localparam int DW    = DATA_WIDTH;
  localparam int GW    = GAIN_WIDTH;
  localparam int GF    = GW / 2;
  localparam int WIDE  = DW + GW + MAG_W;
  localparam logic [31:0] ACCEL_FLOOR = 32'((64'd1 << (DW / 2)) / 64'd100);
  localparam logic [DW-1:0] OUT_HI = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] OUT_LO = {1'b1, {(DW-1){1'b0}}};

  function automatic mag_t sat_shift(logic [WIDE-1:0] x);
    logic [WIDE-1:0] y;
    y = (x > WIDE'(CAP)) ? WIDE'(CAP) : x;
    return MAG_W'(y >> GF);
  endfunction

  function automatic logic [DW-1:0] out_word(mag_t m, logic neg);
    logic [DW-1:0] w;
    if (!neg) w = (m > MAG_W'(OUT_HI)) ? OUT_HI : m[DW-1:0];
    else      w = (m > MAG_W'(OUT_LO)) ? OUT_LO : DW'(-m[DW-1:0]);
    return w;
  endfunction

  cfg_t cfg;

  pdps_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign busy = 1'b0;

  // lane gains
  logic [63:0]   kp_all, kd_all;
  logic [GW-1:0] kp_g [3];
  logic [GW-1:0] kd_g [3];
  logic [GW-1:0] lkp  [3];
  logic [GW-1:0] lkd  [3];

  always_comb begin
    kp_all = 64'(cfg.prop_gains);
    kd_all = 64'(cfg.diff_gains);
    for (int i = 0; i < 3; i++) begin
      kp_g[i] = kp_all[i*GW +: GW];
      kd_g[i] = kd_all[i*GW +: GW];
    end
    for (int i = 0; i < 3; i++) begin
      lkp[i] = cfg.per_axis ? kp_g[i] : kp_g[0];
      lkd[i] = cfg.per_axis ? kd_g[i] : kd_g[0];
    end
  end

  // stage 1: position error and magnitudes
  logic signed [DW-1:0] goal [3];
  logic signed [DW-1:0] pos  [3];
  logic signed [DW-1:0] vel  [3];
  logic signed [DW:0]   derr [3];

  assign goal = '{goal_x, goal_y, goal_z};
  assign pos  = '{pos_x, pos_y, pos_z};
  assign vel  = '{vel_x, vel_y, vel_z};

  always_comb begin
    for (int i = 0; i < 3; i++) derr[i] = {goal[i][DW-1], goal[i]} - {pos[i][DW-1], pos[i]};
  end

  logic          v1, v2, v3;
  logic [DW:0]   dmag1 [3];
  logic [DW-1:0] vmag1 [3];
  logic [2:0]    dneg1, vneg1, dneg2, vneg2, dneg3, vneg3;
  logic [DW+GW:0]   dp2 [3];
  logic [DW+GW-1:0] vp2 [3];
  logic [31+GW:0]   lp2 [3];
  mag_t des3 [3];
  mag_t vm3  [3];
  mag_t lim3 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dneg1[i] <= derr[i][DW];
      dmag1[i] <= derr[i][DW] ? (DW+1)'(-derr[i]) : derr[i];
      vneg1[i] <= vel[i][DW-1];
      vmag1[i] <= vel[i][DW-1] ? DW'(-vel[i]) : vel[i];
      dp2[i]   <= (DW+GW+1)'(dmag1[i]) * (DW+GW+1)'(lkp[i]);
      vp2[i]   <= (DW+GW)'(vmag1[i]) * (DW+GW)'(lkd[i]);
      lp2[i]   <= (32+GW)'(cfg.max_velocity) * (32+GW)'(lkd[i]);
      des3[i]  <= sat_shift(WIDE'(dp2[i]));
      vm3[i]   <= sat_shift(WIDE'(vp2[i]));
      lim3[i]  <= sat_shift(WIDE'(lp2[i]));
    end
    dneg2 <= dneg1;
    vneg2 <= vneg1;
    dneg3 <= dneg2;
    vneg3 <= vneg2;
  end

  // per-axis clamp, then scalar-mode velocity norm limit
  mag3_t des_c;
  vtag_t tag1_in, tag1_out;
  logic  en1, vv4;
  mag3_t des4;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      des_c[i] = (cfg.per_axis && kd_g[i] != '0 && des3[i] > lim3[i]) ? lim3[i] : des3[i];
      tag1_in.vm[i] = vm3[i];
    end
    tag1_in.vneg = vneg3;
    tag1_in.dneg = dneg3;
    en1 = !cfg.per_axis && kd_g[0] != '0;
  end

  pdps_norm_limit #(.TAG_W($bits(vtag_t))) u_vlim (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .in_en     (en1),
    .in_mag    (des_c),
    .in_lim    (lim3[0]),
    .in_tag    (tag1_in),
    .out_valid (vv4),
    .out_mag   (des4),
    .out_tag   (tag1_out)
  );

  // stage 5: command = desired - vel * kd, capped
  logic signed [63:0] sd [3];
  logic signed [63:0] sv [3];
  logic signed [63:0] cx [3];
  logic [63:0]        cm [3];
  logic               v5;
  mag3_t              cmag5;
  logic [2:0]         cneg5;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sd[i] = tag1_out.dneg[i] ? -$signed(64'(des4[i])) : $signed(64'(des4[i]));
      sv[i] = tag1_out.vneg[i] ? -$signed(64'(tag1_out.vm[i])) : $signed(64'(tag1_out.vm[i]));
      cx[i] = sd[i] - sv[i];
      cm[i] = cx[i][63] ? 64'(-cx[i]) : 64'(cx[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else     v5 <= vv4;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      cmag5[i] <= (cm[i] > 64'(CAP)) ? CAP : cm[i][MAG_W-1:0];
      cneg5[i] <= cx[i][63];
    end
  end

  // scalar-mode acceleration norm limit
  logic       en2, vv6;
  mag3_t      cmd6;
  logic [2:0] cneg6;

  assign en2 = !cfg.per_axis && (cfg.max_acceleration > ACCEL_FLOOR);

  pdps_norm_limit #(.TAG_W(3)) u_alim (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .in_en     (en2),
    .in_mag    (cmag5),
    .in_lim    (MAG_W'(cfg.max_acceleration)),
    .in_tag    (cneg5),
    .out_valid (vv6),
    .out_mag   (cmd6),
    .out_tag   (cneg6)
  );

  // output words, axis compaction
  logic [DW-1:0] word [3];
  logic [DW-1:0] rows [3];
  logic [1:0]    cnt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      word[i] = out_word(cmd6[i], cneg6[i]);
      rows[i] = '0;
    end
    cnt = 2'd0;
    if (cfg.per_axis) begin
      for (int i = 0; i < 3; i++) rows[i] = word[i];
      cnt = 2'd3;
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (cfg.axis_select[i]) begin
          rows[cnt] = word[i];
          cnt = cnt + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vv6;
  end

  always_ff @(posedge clk) begin
    accel_row0 <= rows[0];
    accel_row1 <= rows[1];
    accel_row2 <= rows[2];
    row_count  <= cnt;
  end

endmodule
